/* sv/rssi_binned_error_rate_counter_top_assert.svh */
// Assertion macros for the RSSI-binned error rate counter.
`ifndef RSSI_BINNED_ERROR_RATE_COUNTER_TOP_ASSERT_SVH
`define RSSI_BINNED_ERROR_RATE_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RBERC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define RBERC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rberc_pkg.sv */
// Types, constants and helper functions of the RSSI-binned error rate counter.
package rberc_pkg;

  localparam int NUM_BINS    = 64;
  localparam int COUNT_WIDTH = 32;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int ENTRY_W     = 3 * COUNT_WIDTH;
  localparam int CNT_W1      = COUNT_WIDTH + 1;

  localparam int RSSI_STEP   = 5;
  localparam int RECIP_SHIFT = 10;
  localparam int RECIP       = (1 << RECIP_SHIFT) / RSSI_STEP + 1;
  localparam int BIN_OFFSET  = 25;

  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [BIN_W-1:0]       bin_idx_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        expected_byte;
    logic [7:0]        received_byte;
    logic              end_of_packet;
    logic signed [7:0] rssi_dbm;
    logic [5:0]        read_bin;
  } in_word_t;

  typedef struct packed {
    logic        packet_failed;
    logic [15:0] packet_bit_errors;
    logic [5:0]  bin_number;
    logic [31:0] bin_packets;
    logic [31:0] bin_errors;
    logic [31:0] bin_bit_errors;
    logic [31:0] total_packets;
    logic [31:0] total_errors;
  } out_word_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + cnt_t'(1);
  endfunction

  function automatic cnt_t sat_add_bits(input cnt_t v, input logic [15:0] b);
    logic [CNT_W1-1:0] s;
    s = {1'b0, v} + CNT_W1'(b);
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] to_out32(input cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  // Truncate toward zero to a multiple of the step, then offset.
  function automatic logic [5:0] rssi_to_bin(input logic signed [7:0] r);
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [5:0]  q;
    mag  = r[7] ? 8'(-r) : 8'(r);
    prod = 16'(mag) * 16'(RECIP);
    q    = 6'(prod >> RECIP_SHIFT);
    return r[7] ? 6'(BIN_OFFSET) - q : 6'(BIN_OFFSET) + q;
  endfunction

endpackage

/* sv/rberc_if.sv */
// Valid/ready channel interfaces for input and result words.
interface rberc_in_if;
  import rberc_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rberc_out_if;
  import rberc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/rssi_binned_error_rate_counter_top.sv */
// Top level of the RSSI-binned packet and bit error rate counter.
// Input words register into stage 1, then result words into the output register.
// Throughput: one input word per cycle unless output stalls; RAM read-modify-write is
// pipelined with last-write forwarding: back-to-back packets to one bin do not stall.
// Reset: all counters read as zero at once via per-bin valid bits; no clearing pass.
// Packet accumulators and totals are cleared by reset.
`include "rssi_binned_error_rate_counter_top_assert.svh"

module rssi_binned_error_rate_counter_top (
  input logic        clk_i,
  input logic        rst_ni,
  rberc_in_if.sink   in_i,
  rberc_out_if.source out_o
);
  import rberc_pkg::*;

  typedef struct packed {
    logic        upd;
    bin_idx_t    addr;
    logic [5:0]  bin_num;
    logic        in_range;
    logic        pkt_err;
    logic [15:0] pkt_bits;
  } s1_t;

  logic            in_acc;
  logic            in_ready;
  logic            is_pair;
  logic            is_eop;
  logic [7:0]      diff;
  logic [3:0]      pop;
  logic [16:0]     acc_sum;
  logic [15:0]     acc_new;
  logic            mis_new;
  logic [15:0]     acc_q, acc_d;
  logic            mis_q, mis_d;
  logic [5:0]      bin6;
  bin_idx_t        upd_idx;
  s1_t             s1_q, s1_d;
  logic            s1_valid_q;
  logic            s1_adv;
  logic            out_valid_q;
  out_word_t       out_q, out_d;
  logic            ram_re;
  bin_idx_t        ram_raddr;
  logic            ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] entry;
  logic [NUM_BINS-1:0] vld_q;
  logic            wr_vld_q;
  bin_idx_t        wr_addr_q;
  logic [ENTRY_W-1:0] wr_data_q;
  cnt_t            pk, er, bt, pk_n, er_n, bt_n;
  cnt_t            pkt_tot_q, err_tot_q, pkt_tot_d, err_tot_d;

  // Stage 0: accept, accumulate, issue the bin read.
  assign s1_adv    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready  = !s1_valid_q || s1_adv;
  assign in_i.ready = in_ready;
  assign in_acc    = in_i.valid && in_ready;
  assign is_pair   = (in_i.data.kind == KIND_PAIR);
  assign is_eop    = is_pair && in_i.data.end_of_packet;

  assign diff    = in_i.data.expected_byte ^ in_i.data.received_byte;
  assign pop     = 4'($countones(diff));
  assign acc_sum = 17'(acc_q) + 17'(pop);
  assign acc_new = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
  assign mis_new = mis_q | (|diff);

  assign bin6    = rssi_to_bin(in_i.data.rssi_dbm);
  assign upd_idx = (int'(bin6) >= NUM_BINS) ? BIN_W'(NUM_BINS - 1) : BIN_W'(bin6);

  always_comb begin
    acc_d = acc_q;
    mis_d = mis_q;
    if (in_acc && is_pair) begin
      acc_d = is_eop ? 16'd0 : acc_new;
      mis_d = is_eop ? 1'b0 : mis_new;
    end
  end

  always_comb begin
    s1_d.upd      = is_eop;
    s1_d.addr     = is_pair ? upd_idx : BIN_W'(in_i.data.read_bin);
    s1_d.bin_num  = is_pair ? 6'(upd_idx) : in_i.data.read_bin;
    s1_d.in_range = is_pair || (int'(in_i.data.read_bin) < NUM_BINS);
    s1_d.pkt_err  = is_pair ? mis_new : 1'b0;
    s1_d.pkt_bits = is_pair ? acc_new : 16'd0;
  end

  assign ram_re    = in_acc && (!is_pair || is_eop);
  assign ram_raddr = s1_d.addr;

  rberc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BINS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Stage 1: forward, modify, write back, load the result word.
  always_comb begin
    if (wr_vld_q && (wr_addr_q == s1_q.addr)) begin
      entry = wr_data_q;
    end else if (vld_q[s1_q.addr]) begin
      entry = ram_rdata;
    end else begin
      entry = '0;
    end
    if (!s1_q.in_range) begin
      entry = '0;
    end
  end

  assign pk = entry[ENTRY_W-1 -: COUNT_WIDTH];
  assign er = entry[2*COUNT_WIDTH-1 -: COUNT_WIDTH];
  assign bt = entry[COUNT_WIDTH-1:0];

  assign pk_n = sat_inc(pk);
  assign er_n = s1_q.pkt_err ? sat_inc(er) : er;
  assign bt_n = s1_q.pkt_err ? sat_add_bits(bt, s1_q.pkt_bits) : bt;
  assign pkt_tot_d = sat_inc(pkt_tot_q);
  assign err_tot_d = s1_q.pkt_err ? sat_inc(err_tot_q) : err_tot_q;

  assign ram_we    = s1_adv && s1_q.upd;
  assign ram_wdata = {pk_n, er_n, bt_n};

  always_comb begin
    out_d.packet_failed     = s1_q.pkt_err;
    out_d.packet_bit_errors = s1_q.pkt_bits;
    out_d.bin_number        = s1_q.bin_num;
    out_d.bin_packets       = to_out32(s1_q.upd ? pk_n : pk);
    out_d.bin_errors        = to_out32(s1_q.upd ? er_n : er);
    out_d.bin_bit_errors    = to_out32(s1_q.upd ? bt_n : bt);
    out_d.total_packets     = to_out32(s1_q.upd ? pkt_tot_d : pkt_tot_q);
    out_d.total_errors      = to_out32(s1_q.upd ? err_tot_d : err_tot_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      mis_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      wr_vld_q    <= 1'b0;
      pkt_tot_q   <= '0;
      err_tot_q   <= '0;
    end else begin
      acc_q <= acc_d;
      mis_q <= mis_d;
      if (in_acc && (!is_pair || is_eop)) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[s1_q.addr] <= 1'b1;
        wr_vld_q         <= 1'b1;
        pkt_tot_q        <= pkt_tot_d;
        err_tot_q        <= err_tot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
    if (ram_we) begin
      wr_addr_q <= s1_q.addr;
      wr_data_q <= ram_wdata;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `RBERC_ASSERT_IMP(a_no_accept_on_stall, s1_valid_q && !s1_adv, !in_acc,
                    "input accepted while stage 1 is stalled")
  `RBERC_ASSERT_IMP(a_write_on_update, ram_we, s1_valid_q && s1_q.upd,
                    "bin write without a packet update in stage 1")
  `RBERC_ASSERT_NXT(a_clear_after_eop, in_acc && is_eop, (acc_q == 16'd0) && !mis_q,
                    "packet accumulators not cleared after last pair")
  `RBERC_ASSERT_IMP(a_totals_order, 1'b1, err_tot_q <= pkt_tot_q,
                    "error total exceeds packet total")

endmodule

/* sv/rberc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rberc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* tb/rssi_binned_error_rate_counter_top_test.sv */
// Self-checking testbench for the RSSI-binned error rate counter: directed table, then random words.
`timescale 1ns / 100ps

module rssi_binned_error_rate_counter_top_test;
  import rberc_pkg::*;

  localparam int DBM_PER_BIN  = 5;
  localparam int BIN_BIAS     = 25;
  localparam int RANDOM_WORDS = 1700;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 250;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rberc_in_if  in_if ();
  rberc_out_if out_if ();

  rssi_binned_error_rate_counter_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [15:0] pkt_bit_errs;
  logic        pkt_mismatch;
  logic [31:0] bin_pkts [NUM_BINS];
  logic [31:0] bin_errs [NUM_BINS];
  logic [31:0] bin_bits [NUM_BINS];
  logic [31:0] all_pkts;
  logic [31:0] all_errs;

  out_word_t   bin_reports_due [$];
  plan_row_t   plan [$];
  int          mismatches   = 0;
  int          results_seen = 0;
  bit          gaps_on      = 1'b1;
  bit          held_off     = 1'b0;
  int          cycles       = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Advance the counter state by one word; return 1 when a report is due.
  function automatic bit tally_word(input in_word_t w, output out_word_t r);
    logic [16:0] acc;
    int          dbm;
    int          slot;
    r = '0;
    if (w.kind == KIND_READ) begin
      r.bin_number = w.read_bin;
      if (int'(w.read_bin) < NUM_BINS) begin
        r.bin_packets    = bin_pkts[w.read_bin];
        r.bin_errors     = bin_errs[w.read_bin];
        r.bin_bit_errors = bin_bits[w.read_bin];
      end
      r.total_packets = all_pkts;
      r.total_errors  = all_errs;
      return 1'b1;
    end
    if (w.expected_byte != w.received_byte) begin
      pkt_mismatch = 1'b1;
      acc = {1'b0, pkt_bit_errs} + 17'($countones(w.expected_byte ^ w.received_byte));
      pkt_bit_errs = acc[16] ? 16'hFFFF : acc[15:0];
    end
    if (!w.end_of_packet) return 1'b0;
    dbm  = int'(w.rssi_dbm);
    slot = dbm / DBM_PER_BIN + BIN_BIAS;
    if (slot < 0) slot = 0;
    if (slot >= NUM_BINS) slot = NUM_BINS - 1;
    bin_pkts[slot] = sat32(bin_pkts[slot], 32'd1);
    all_pkts       = sat32(all_pkts, 32'd1);
    if (pkt_mismatch) begin
      bin_errs[slot] = sat32(bin_errs[slot], 32'd1);
      all_errs       = sat32(all_errs, 32'd1);
      bin_bits[slot] = sat32(bin_bits[slot], 32'(pkt_bit_errs));
    end
    r.packet_failed     = pkt_mismatch;
    r.packet_bit_errors = pkt_bit_errs;
    r.bin_number        = 6'(slot);
    r.bin_packets       = bin_pkts[slot];
    r.bin_errors        = bin_errs[slot];
    r.bin_bit_errors    = bin_bits[slot];
    r.total_packets     = all_pkts;
    r.total_errors      = all_errs;
    pkt_bit_errs = '0;
    pkt_mismatch = 1'b0;
    return 1'b1;
  endfunction

  function automatic in_word_t pair_word(input logic [7:0] e, input logic [7:0] r,
                                         input logic eop, input int dbm);
    in_word_t w;
    w.kind          = KIND_PAIR;
    w.expected_byte = e;
    w.received_byte = r;
    w.end_of_packet = eop;
    w.rssi_dbm      = 8'(dbm);
    w.read_bin      = 6'($urandom);
    return w;
  endfunction

  function automatic in_word_t read_word(input logic [5:0] bin);
    in_word_t w;
    w.kind          = KIND_READ;
    w.expected_byte = 8'($urandom);
    w.received_byte = 8'($urandom);
    w.end_of_packet = 1'($urandom);
    w.rssi_dbm      = 8'($urandom);
    w.read_bin      = bin;
    return w;
  endfunction

  function automatic out_word_t report(input logic pe, input logic [15:0] bits,
                                       input logic [5:0] bin, input logic [31:0] bp,
                                       input logic [31:0] be, input logic [31:0] bbe,
                                       input logic [31:0] tp, input logic [31:0] te);
    out_word_t r;
    r.packet_failed     = pe;
    r.packet_bit_errors = bits;
    r.bin_number        = bin;
    r.bin_packets       = bp;
    r.bin_errors        = be;
    r.bin_bit_errors    = bbe;
    r.total_packets     = tp;
    r.total_errors      = te;
    return r;
  endfunction

  function automatic void add_row(input in_word_t w, input logic typed, input out_word_t want);
    plan_row_t row;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  // Offer one word, starting at a falling edge; return at the falling edge after acceptance.
  task automatic send_word(input in_word_t w, input logic typed, input out_word_t typed_want);
    out_word_t r;
    bit        due;
    while (gaps_on && $urandom_range(99) < 34) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    due = tally_word(w, r);
    if (due) bin_reports_due.push_back(typed ? typed_want : r);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && results_seen >= HOLD_AT) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_if.ready <= !(gaps_on && $urandom_range(99) < 34);
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    out_word_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (bin_reports_due.size() == 0) begin
        $error("unexpected result word: %h", got);
        mismatches++;
      end else begin
        want = bin_reports_due.pop_front();
        check_field("packet_failed", 32'(want.packet_failed), 32'(got.packet_failed));
        check_field("packet_bit_errors", 32'(want.packet_bit_errors),
                    32'(got.packet_bit_errors));
        check_field("bin_number", 32'(want.bin_number), 32'(got.bin_number));
        check_field("bin_packets", want.bin_packets, got.bin_packets);
        check_field("bin_errors", want.bin_errors, got.bin_errors);
        check_field("bin_bit_errors", want.bin_bit_errors, got.bin_bit_errors);
        check_field("total_packets", want.total_packets, got.total_packets);
        check_field("total_errors", want.total_errors, got.total_errors);
      end
      results_seen++;
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int          n;
    int          plen;
    logic [7:0]  e;
    logic [7:0]  r;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    pkt_bit_errs = '0;
    pkt_mismatch = 1'b0;
    all_pkts     = '0;
    all_errs     = '0;
    foreach (bin_pkts[i]) begin
      bin_pkts[i] = '0;
      bin_errs[i] = '0;
      bin_bits[i] = '0;
    end

    add_row(read_word(6'd0), 1'b1,
            report(1'b0, 16'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    add_row(read_word(6'd63), 1'b1,
            report(1'b0, 16'd0, 6'd63, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    add_row(pair_word(8'hFF, 8'h00, 1'b1, -128), 1'b1,
            report(1'b1, 16'd8, 6'd0, 32'd1, 32'd1, 32'd8, 32'd1, 32'd1));
    add_row(pair_word(8'h00, 8'h00, 1'b1, 127), 1'b1,
            report(1'b0, 16'd0, 6'd50, 32'd1, 32'd0, 32'd0, 32'd2, 32'd1));
    add_row(pair_word(8'hAA, 8'h55, 1'b0, -77),    1'b0, '0);
    add_row(pair_word(8'h0F, 8'h0E, 1'b0, 33),     1'b0, '0);
    add_row(pair_word(8'h3C, 8'h3C, 1'b1, -1),     1'b0, '0);
    add_row(pair_word(8'h01, 8'h00, 1'b0, 90),     1'b0, '0);
    add_row(read_word(6'd25),                      1'b0, '0);
    add_row(pair_word(8'h80, 8'h80, 1'b1, 4),      1'b0, '0);
    add_row(pair_word(8'h00, 8'h01, 1'b1, -5),     1'b0, '0);
    add_row(pair_word(8'h00, 8'h00, 1'b1, -4),     1'b0, '0);
    add_row(pair_word(8'h7E, 8'h7E, 1'b1, 5),      1'b0, '0);
    add_row(pair_word(8'hC3, 8'h3C, 1'b1, -6),     1'b0, '0);
    add_row(pair_word(8'h10, 8'h10, 1'b1, 6),      1'b0, '0);
    add_row(pair_word(8'hFE, 8'hFF, 1'b1, -125),   1'b0, '0);
    add_row(pair_word(8'h55, 8'h55, 1'b1, 125),    1'b0, '0);
    add_row(pair_word(8'h00, 8'h00, 1'b1, 0),      1'b0, '0);
    add_row(pair_word(8'h81, 8'h18, 1'b1, -127),   1'b0, '0);
    add_row(pair_word(8'h00, 8'h00, 1'b1, -124),   1'b0, '0);
    add_row(pair_word(8'hF0, 8'h0F, 1'b1, 124),    1'b0, '0);
    add_row(read_word(6'd50),                      1'b0, '0);
    add_row(read_word(6'd51),                      1'b0, '0);
    add_row(read_word(6'd24),                      1'b0, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want);

    n = 0;
    while (n < RANDOM_WORDS) begin
      gaps_on = !(n >= 700 && n < 1000);
      if ($urandom_range(99) < 15) begin
        send_word(read_word(6'($urandom_range(63))), 1'b0, '0);
        n++;
      end else begin
        plen = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
        for (int i = 1; i <= plen; i++) begin
          if ($urandom_range(99) < 5) begin
            send_word(read_word(6'($urandom_range(63))), 1'b0, '0);
            n++;
          end
          e = 8'($urandom);
          case ($urandom_range(3))
            0, 1:    r = e;
            2:       r = e ^ (8'h01 << $urandom_range(7));
            default: r = 8'($urandom);
          endcase
          send_word(pair_word(e, r, i == plen, int'($urandom_range(255)) - 128), 1'b0, '0);
          n++;
        end
      end
    end
    gaps_on = 1'b1;
    in_if.valid <= 1'b0;

    wait (bin_reports_due.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
